/* sv/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg
// Shared constants and control types for the priority ready queue.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int PRIO_BITS_DEF   = 8;
   localparam int ID_BITS_DEF     = 8;

   localparam int FIELD_ID_W   = 8;
   localparam int FIELD_PRIO_W = 8;
   localparam int FIELD_OCC_W  = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic load;
      logic insert;
      logic remove;
      logic drop;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } status_type;

endpackage

`default_nettype wire

/* sv/priority_ready_queue.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue
// Stable priority queue of process ids held in a sorted shift array.
// A request's response is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle while responses are taken; the whole
// insert or pop is one shift of the slot array.
// Reset clears the fill count and the controller state; slots and response
// fields hold no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue #(
   parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
   parameter int PRIO_BITS   = prq_pkg::PRIO_BITS_DEF,
   parameter int ID_BITS     = prq_pkg::ID_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [prq_pkg::FIELD_ID_W-1:0]    req_proc_id,
   input  wire logic [prq_pkg::FIELD_PRIO_W-1:0]  req_prio,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [prq_pkg::FIELD_ID_W-1:0]         rsp_out_id,
   output logic                                   rsp_out_valid,
   output logic                                   rsp_insert_dropped,
   output logic [prq_pkg::FIELD_OCC_W-1:0]        rsp_occupancy
);

   prq_pkg::cmd_type    cmd;
   prq_pkg::status_type status;

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   prq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PRIO_BITS   (PRIO_BITS),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_proc_id        (req_proc_id),
      .req_prio           (req_prio),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_insert_dropped (rsp_insert_dropped),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

`default_nettype wire

/* sv/prq_ctrl.sv */
// ----------------------------------------------------------------------------
// prq_ctrl
// Handshake controller: accepts requests, issues datapath commands and
// holds the result until the response side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_kind,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire prq_pkg::status_type  status,
   output prq_pkg::cmd_type          cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_HOLD = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_stall = (state_ff == ST_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      cmd.load   = accept;
      cmd.insert = accept && (req_kind == prq_pkg::KIND_INSERT) && !status.full;
      cmd.remove = accept && (req_kind == prq_pkg::KIND_REMOVE) && !status.empty;
      cmd.drop   = accept && (req_kind == prq_pkg::KIND_INSERT) && status.full;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!accept && !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.remove) && !(cmd.insert && cmd.drop))
      else $error("conflicting commands");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("accepted request produced no response");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      cmd.drop |-> status.full && !status.empty)
      else $error("drop while not full");

endmodule

`default_nettype wire

/* sv/prq_datapath.sv */
// ----------------------------------------------------------------------------
// prq_datapath
// Sorted shift array of slots, fill count and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_datapath #(
   parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
   parameter int PRIO_BITS   = prq_pkg::PRIO_BITS_DEF,
   parameter int ID_BITS     = prq_pkg::ID_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire prq_pkg::cmd_type                    cmd,
   output prq_pkg::status_type                      status,
   input  wire logic [prq_pkg::FIELD_ID_W-1:0]      req_proc_id,
   input  wire logic [prq_pkg::FIELD_PRIO_W-1:0]    req_prio,
   output logic [prq_pkg::FIELD_ID_W-1:0]           rsp_out_id,
   output logic                                     rsp_out_valid,
   output logic                                     rsp_insert_dropped,
   output logic [prq_pkg::FIELD_OCC_W-1:0]          rsp_occupancy
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ID_BITS-1:0]   slot_id_ff   [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0] slot_prio_ff [QUEUE_DEPTH];
   logic [ID_BITS-1:0]   slot_id_in   [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0] slot_prio_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] slot_lower;
   logic [QUEUE_DEPTH-1:0] at_tail;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic [31:0]          id_wide;
   logic [31:0]          prio_wide;
   logic [31:0]          head_wide;
   logic [31:0]          occ_wide;
   logic [ID_BITS-1:0]   new_id;
   logic [PRIO_BITS-1:0] new_prio;

   logic [prq_pkg::FIELD_ID_W-1:0]  rsp_id_ff;
   logic                            rsp_ok_ff;
   logic                            rsp_drop_ff;
   logic [prq_pkg::FIELD_OCC_W-1:0] rsp_occ_ff;

   assign id_wide   = 32'(req_proc_id);
   assign prio_wide = 32'(req_prio);
   assign new_id    = id_wide[ID_BITS-1:0];
   assign new_prio  = prio_wide[PRIO_BITS-1:0];
   assign head_wide = 32'(slot_id_ff[0]);

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      logic                 prev_lower;
      logic [ID_BITS-1:0]   prev_id;
      logic [PRIO_BITS-1:0] prev_prio;
      logic [ID_BITS-1:0]   next_id;
      logic [PRIO_BITS-1:0] next_prio;

      assign slot_lower[i] = (count_ff > CNT_W'(i)) && (slot_prio_ff[i] < new_prio);
      assign at_tail[i]    = (count_ff == CNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_lower = 1'b0;
         assign prev_id    = new_id;
         assign prev_prio  = new_prio;
      end else begin : g_body
         assign prev_lower = slot_lower[i-1];
         assign prev_id    = slot_id_ff[i-1];
         assign prev_prio  = slot_prio_ff[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_id   = slot_id_ff[i];
         assign next_prio = slot_prio_ff[i];
      end else begin : g_inner
         assign next_id   = slot_id_ff[i+1];
         assign next_prio = slot_prio_ff[i+1];
      end

      always_comb begin
         slot_id_in[i]   = slot_id_ff[i];
         slot_prio_in[i] = slot_prio_ff[i];
         if (cmd.insert && (slot_lower[i] || at_tail[i])) begin
            if (prev_lower) begin
               slot_id_in[i]   = prev_id;
               slot_prio_in[i] = prev_prio;
            end else begin
               slot_id_in[i]   = new_id;
               slot_prio_in[i] = new_prio;
            end
         end else if (cmd.remove) begin
            slot_id_in[i]   = next_id;
            slot_prio_in[i] = next_prio;
         end
      end

      always_ff @(posedge clock) begin
         slot_id_ff[i]   <= slot_id_in[i];
         slot_prio_ff[i] <= slot_prio_in[i];
      end
   end

   always_comb begin
      priority if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign occ_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_id_ff   <= cmd.remove ? head_wide[prq_pkg::FIELD_ID_W-1:0] : '0;
         rsp_ok_ff   <= cmd.remove;
         rsp_drop_ff <= cmd.drop;
         rsp_occ_ff  <= occ_wide[prq_pkg::FIELD_OCC_W-1:0];
      end
   end

   assign rsp_out_id         = rsp_id_ff;
   assign rsp_out_valid      = rsp_ok_ff;
   assign rsp_insert_dropped = rsp_drop_ff;
   assign rsp_occupancy      = rsp_occ_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the queue");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not shrink the queue");

endmodule

`default_nettype wire

/* dv/prq_order_checker.sv */
// ----------------------------------------------------------------------------
// prq_order_checker
// Watches the request and response channels of the priority ready queue and
// keeps its own sorted copy of the queue. Every accepted request predicts one
// response; accepted responses are compared field by field, in order, with
// the oldest prediction. Mismatch and outstanding counts go to the bench top.
// ----------------------------------------------------------------------------
module prq_order_checker
   import prq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_kind,
   input  logic [FIELD_ID_W-1:0]   req_proc_id,
   input  logic [FIELD_PRIO_W-1:0] req_prio,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [FIELD_ID_W-1:0]   rsp_out_id,
   input  logic                    rsp_out_valid,
   input  logic                    rsp_insert_dropped,
   input  logic [FIELD_OCC_W-1:0]  rsp_occupancy,
   output int                      mismatches,
   output int                      owed,
   output int                      served,
   output int                      refused
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = QUEUE_DEPTH_DEF;

   typedef struct packed {
      logic [FIELD_ID_W-1:0]  out_id;
      logic                   out_valid;
      logic                   dropped;
      logic [FIELD_OCC_W-1:0] occupancy;
   } queue_reply_type;

   logic [FIELD_ID_W-1:0]   held_id   [DEPTH];
   logic [FIELD_PRIO_W-1:0] held_prio [DEPTH];
   int                      held_count;
   queue_reply_type         owed_replies[$];

   function automatic queue_reply_type apply_request(input logic                    kind,
                                                     input logic [FIELD_ID_W-1:0]   id,
                                                     input logic [FIELD_PRIO_W-1:0] prio);
      queue_reply_type r;
      int              pos;
      r = '0;
      if (kind == KIND_INSERT) begin
         if (held_count >= DEPTH) begin
            r.dropped = 1'b1;
         end else begin
            pos = 0;
            while (pos < held_count && held_prio[pos] >= prio) pos++;
            for (int i = held_count; i > pos; i--) begin
               held_id[i]   = held_id[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_id[pos]   = id;
            held_prio[pos] = prio;
            held_count++;
         end
      end else if (held_count > 0) begin
         r.out_id    = held_id[0];
         r.out_valid = 1'b1;
         for (int i = 1; i < held_count; i++) begin
            held_id[i-1]   = held_id[i];
            held_prio[i-1] = held_prio[i];
         end
         held_count--;
      end
      r.occupancy = FIELD_OCC_W'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_reply_type want;
      queue_reply_type got;
      if (reset) begin
         held_count = 0;
         owed_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_id, rsp_out_valid, rsp_insert_dropped, rsp_occupancy};
            if (owed_replies.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("%0t: response with no request outstanding: id=%0d valid=%0b",
                           $realtime, got.out_id, got.out_valid);
            end else begin
               want = owed_replies.pop_front();
               if (got.out_id !== want.out_id || got.out_valid !== want.out_valid ||
                   got.dropped !== want.dropped || got.occupancy !== want.occupancy) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("%0t: mismatch: expected id=%0d valid=%0b drop=%0b occ=%0d, %s",
                              $realtime, want.out_id, want.out_valid, want.dropped,
                              want.occupancy,
                              $sformatf("got id=%0d valid=%0b drop=%0b occ=%0d",
                                        got.out_id, got.out_valid, got.dropped,
                                        got.occupancy));
               end
               if (want.out_valid) served <= served + 1;
               if (want.dropped) refused <= refused + 1;
            end
         end
         if (req_valid && !req_stall)
            owed_replies.push_back(apply_request(req_kind, req_proc_id, req_prio));
      end
      owed <= owed_replies.size();
   end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Bench top for the priority ready queue: directed fill, overflow and drain,
// then random insert/pop bursts under four sender/receiver idle mixes.
// Checking lives in prq_order_checker; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import prq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 482;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_kind = KIND_INSERT;
   logic [FIELD_ID_W-1:0]   req_proc_id = '0;
   logic [FIELD_PRIO_W-1:0] req_prio = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [FIELD_ID_W-1:0]   rsp_out_id;
   logic                    rsp_out_valid;
   logic                    rsp_insert_dropped;
   logic [FIELD_OCC_W-1:0]  rsp_occupancy;

   int mismatches;
   int owed;
   int served;
   int refused;
   int sent = 0;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   priority_ready_queue u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_proc_id        (req_proc_id),
      .req_prio           (req_prio),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_insert_dropped (rsp_insert_dropped),
      .rsp_occupancy      (rsp_occupancy)
   );

   prq_order_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_proc_id        (req_proc_id),
      .req_prio           (req_prio),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_insert_dropped (rsp_insert_dropped),
      .rsp_occupancy      (rsp_occupancy),
      .mismatches         (mismatches),
      .owed               (owed),
      .served             (served),
      .refused            (refused)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, owed);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_request(input logic                    kind,
                               input logic [FIELD_ID_W-1:0]   id,
                               input logic [FIELD_PRIO_W-1:0] prio);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_proc_id <= id;
      req_prio    <= prio;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   function automatic logic [FIELD_PRIO_W-1:0] pick_prio();
      case ($urandom_range(3))
         0:       return FIELD_PRIO_W'($urandom_range(3));
         1:       return FIELD_PRIO_W'($urandom_range(255));
         2:       return $urandom_range(1) ? '1 : '0;
         default: return FIELD_PRIO_W'($urandom_range(255, 252));
      endcase
   endfunction

   initial begin
      int                      fill_prio [16];
      int                      target;
      int                      burst_len;
      int                      insert_pct;
      logic                    kind;
      fill_prio = '{0, 255, 255, 128, 128, 128, 0, 1, 254, 128, 255, 0, 64, 64, 200, 1};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pop empty, fill to the brim with ties and extremes, overflow, partial drain
      send_request(KIND_REMOVE, '1, '1);
      for (int i = 0; i < 16; i++)
         send_request(KIND_INSERT, FIELD_ID_W'(255 - i * 17), FIELD_PRIO_W'(fill_prio[i]));
      send_request(KIND_INSERT, 8'h5A, '1);
      repeat (6) send_request(KIND_REMOVE, FIELD_ID_W'($urandom), FIELD_PRIO_W'($urandom));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 80; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 17; stall_pct = 17; end
         endcase
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            burst_len = $urandom_range(40, 4);
            case ($urandom_range(2))
               0:       insert_pct = 85;
               1:       insert_pct = 20;
               default: insert_pct = 50;
            endcase
            repeat (burst_len) begin
               kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
               send_request(kind, FIELD_ID_W'($urandom), pick_prio());
            end
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (owed != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d requests sent across no-idle, sender-idle, receiver-stall and mixed phases",
               sent);
      $display("%0d pops returned an entry, %0d inserts refused on a full queue",
               served, refused);
      if (mismatches == 0 && owed == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", mismatches, owed);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
sv/prq_pkg.sv
sv/prq_ctrl.sv
sv/prq_datapath.sv
sv/priority_ready_queue.sv
dv/prq_order_checker.sv
dv/tb.sv
